>>> src/arfs_pkg.sv
// shared types and constants of the audio ring fifo with silence fill
`timescale 1ns / 1ps

package arfs_pkg;

  // default sizes
  localparam int RING_BYTES   = 16384;
  localparam int BUFFER_BYTES = 8192;
  localparam int BUFFER_SLOTS = 6;
  localparam int FRAME_BYTES  = 4;
  localparam int QUEUE_DEPTH  = 4;

  // ring address field in a queue entry, wide enough for the largest ring
  localparam int RING_ADDR_W = 20;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PAUSE = 3'd0;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_PULL  = 2'd1,
    MODE_FLUSH = 2'd2
  } arfs_mode_e;

  typedef enum logic [1:0] {
    RING_NONE  = 2'd0,
    RING_WRITE = 2'd1,
    RING_READ  = 2'd2
  } arfs_ring_op_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] push_byte;
  } arfs_in_t;

  typedef struct packed {
    logic        push_accepted;
    logic [7:0]  out_byte;
    logic        buffer_last;
    logic [14:0] queued_bytes;
    logic [39:0] played_frames;
    logic [31:0] underrun_count;
  } arfs_out_t;

  // one classified request on its way to the ring store
  typedef struct packed {
    arfs_ring_op_e          op;
    logic [RING_ADDR_W-1:0] addr;
    logic [7:0]             wdata;
    arfs_out_t              rsp;
  } arfs_entry_t;

endpackage

>>> src/arfs_front.sv
// front end: accepts requests, keeps ring and buffer bookkeeping, issues ring ops
`timescale 1ns / 1ps

module arfs_front #(
  parameter int RingBytes   = arfs_pkg::RING_BYTES,
  parameter int BufferBytes = arfs_pkg::BUFFER_BYTES,
  parameter int BufferSlots = arfs_pkg::BUFFER_SLOTS,
  parameter int FrameBytes  = arfs_pkg::FRAME_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pause_i,
  input  logic                  in_valid_i,
  input  arfs_pkg::arfs_in_t    in_req_i,
  output logic                  in_stall_o,
  output logic                  q_push_o,
  output arfs_pkg::arfs_entry_t q_entry_o,
  input  logic                  q_full_i
);
  import arfs_pkg::*;

  localparam int PW  = $clog2(RingBytes);
  localparam int FW  = $clog2(RingBytes + 1);
  localparam int BPW = $clog2(BufferBytes);
  localparam int RW  = $clog2(BufferBytes + 1);
  localparam int SW  = $clog2(BufferSlots);
  localparam int FRW = $clog2(BufferBytes / FrameBytes + 1);
  // reciprocal for the frame count, exact for any RW-bit numerator
  localparam int RecipShift = RW + 3;
  localparam logic [RW+3:0] Recip = (RW+4)'((2 ** RecipShift + FrameBytes - 1) / FrameBytes);

  logic [PW-1:0]  read_pos_q, read_pos_d;
  logic [PW-1:0]  write_pos_q, write_pos_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [BPW-1:0] buffer_pos_q, buffer_pos_d;
  logic [RW-1:0]  real_left_q, real_left_d;
  logic [SW-1:0]  slot_q, slot_d;
  logic [FRW-1:0] slot_frames_q [BufferSlots];
  logic [FRW-1:0] slot_frames_d [BufferSlots];
  logic [39:0]    frame_clock_q, frame_clock_d;
  logic [31:0]    underruns_q, underruns_d;

  logic           accept;
  logic           starting;
  logic [RW-1:0]  real_cnt;
  logic [RW-1:0]  rl;
  logic [2*RW+3:0] prod;
  logic [FRW-1:0] frames;
  arfs_entry_t    ent;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign q_entry_o  = ent;

  always_comb begin
    read_pos_d    = read_pos_q;
    write_pos_d   = write_pos_q;
    fill_d        = fill_q;
    buffer_pos_d  = buffer_pos_q;
    real_left_d   = real_left_q;
    slot_d        = slot_q;
    slot_frames_d = slot_frames_q;
    frame_clock_d = frame_clock_q;
    underruns_d   = underruns_q;
    ent           = '0;
    ent.op        = RING_NONE;

    starting = (buffer_pos_q == '0);
    if (pause_i) begin
      real_cnt = '0;
    end else if (32'(fill_q) >= 32'(BufferBytes)) begin
      real_cnt = RW'(BufferBytes);
    end else begin
      real_cnt = RW'(fill_q);
    end
    prod   = {{(RW+4){1'b0}}, real_cnt} * {{RW{1'b0}}, Recip};
    frames = FRW'(prod >> RecipShift);
    rl     = starting ? real_cnt : real_left_q;

    if (accept) begin
      unique case (arfs_mode_e'(in_req_i.mode))
        MODE_PUSH: begin
          if (32'(fill_q) < 32'(RingBytes)) begin
            ent.op    = RING_WRITE;
            ent.addr  = RING_ADDR_W'(write_pos_q);
            ent.wdata = in_req_i.push_byte;
            ent.rsp.push_accepted = 1'b1;
            write_pos_d = (write_pos_q == PW'(RingBytes - 1)) ? '0 : write_pos_q + 1'b1;
            fill_d      = fill_q + 1'b1;
          end
        end
        MODE_PULL: begin
          if (starting) begin
            frame_clock_d = frame_clock_q + 40'(slot_frames_q[slot_q]);
            if (!pause_i && 32'(real_cnt) < 32'(BufferBytes) && underruns_q != '1) begin
              underruns_d = underruns_q + 1'b1;
            end
            slot_frames_d[slot_q] = frames;
          end
          if (rl != '0 && fill_q != '0) begin
            ent.op      = RING_READ;
            ent.addr    = RING_ADDR_W'(read_pos_q);
            read_pos_d  = (read_pos_q == PW'(RingBytes - 1)) ? '0 : read_pos_q + 1'b1;
            fill_d      = fill_q - 1'b1;
            real_left_d = rl - 1'b1;
          end else begin
            real_left_d = '0;
          end
          if (buffer_pos_q == BPW'(BufferBytes - 1)) begin
            ent.rsp.buffer_last = 1'b1;
            buffer_pos_d = '0;
            slot_d = (slot_q == SW'(BufferSlots - 1)) ? '0 : slot_q + 1'b1;
          end else begin
            buffer_pos_d = buffer_pos_q + 1'b1;
          end
        end
        MODE_FLUSH: begin
          read_pos_d    = '0;
          write_pos_d   = '0;
          fill_d        = '0;
          frame_clock_d = '0;
          real_left_d   = '0;
        end
        default: ;
      endcase
    end

    ent.rsp.queued_bytes   = 15'(fill_d);
    ent.rsp.played_frames  = frame_clock_d;
    ent.rsp.underrun_count = underruns_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_pos_q    <= '0;
      write_pos_q   <= '0;
      fill_q        <= '0;
      buffer_pos_q  <= '0;
      real_left_q   <= '0;
      slot_q        <= '0;
      slot_frames_q <= '{default: '0};
      frame_clock_q <= '0;
      underruns_q   <= '0;
    end else begin
      read_pos_q    <= read_pos_d;
      write_pos_q   <= write_pos_d;
      fill_q        <= fill_d;
      buffer_pos_q  <= buffer_pos_d;
      real_left_q   <= real_left_d;
      slot_q        <= slot_d;
      slot_frames_q <= slot_frames_d;
      frame_clock_q <= frame_clock_d;
      underruns_q   <= underruns_d;
    end
  end

endmodule

>>> src/arfs_queue.sv
// short in-order queue of ring ops between front and back
`timescale 1ns / 1ps

module arfs_queue #(
  parameter int Depth = arfs_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  arfs_pkg::arfs_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output arfs_pkg::arfs_entry_t head_o
);
  import arfs_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  arfs_entry_t    slots_q [Depth];
  logic [AW-1:0]  wptr_q, rptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> src/arfs_back.sv
// back end: ring byte store and the registered result stage
`timescale 1ns / 1ps

module arfs_back #(
  parameter int RingBytes = arfs_pkg::RING_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  arfs_pkg::arfs_entry_t q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  output arfs_pkg::arfs_out_t   out_rsp_o,
  input  logic                  out_stall_i
);
  import arfs_pkg::*;

  localparam int PW = $clog2(RingBytes);

  logic [7:0]    ring_mem [RingBytes];
  logic [7:0]    rd_q;
  arfs_entry_t   meta_q;
  logic          valid_q;
  logic          advance;
  logic [PW-1:0] addr;

  assign advance = !valid_q || !out_stall_i;
  assign q_pop_o = advance && !q_empty_i;
  assign addr    = q_head_i.addr[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_head_i.op == RING_WRITE) begin
      ring_mem[addr] <= q_head_i.wdata;
    end
    if (q_pop_o && q_head_i.op == RING_READ) begin
      rd_q <= ring_mem[addr];
    end
    if (q_pop_o) begin
      meta_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= !q_empty_i;
    end
  end

  always_comb begin
    out_rsp_o = meta_q.rsp;
    // silence and non-pull requests give a zero byte
    out_rsp_o.out_byte = (meta_q.op == RING_READ) ? rd_q : 8'h00;
  end

  assign out_valid_o = valid_q;

endmodule

>>> src/audio_ring_fifo_silence_fill.sv
// top level: audio ring fifo with silence fill and apb configuration
// channel   dir  handshake                 payload
// in        in   in_valid_i / in_stall_o   in_req_i   (mode, push_byte)
// out       out  out_valid_o / out_stall_i out_rsp_o  (status and byte per request)
// cfg       in   psel/penable/pwrite/pready paddr, pwdata, prdata (pause_output)
// one request per cycle sustained while the input is not stalled; each request passes the
// front bookkeeping into the op queue and then the registered ring store read stage.
// reset clears all counters and positions; the ring store itself is not cleared.
// a stalled output backs up the op queue, and the input stalls once it is full.
`timescale 1ns / 1ps

module audio_ring_fifo_silence_fill #(
  parameter int RingBytes   = arfs_pkg::RING_BYTES,
  parameter int BufferBytes = arfs_pkg::BUFFER_BYTES,
  parameter int BufferSlots = arfs_pkg::BUFFER_SLOTS,
  parameter int FrameBytes  = arfs_pkg::FRAME_BYTES,
  parameter int QueueDepth  = arfs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  arfs_pkg::arfs_in_t              in_req_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  output arfs_pkg::arfs_out_t             out_rsp_o,
  input  logic                            out_stall_i,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [arfs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import arfs_pkg::*;

  logic        pause_q;
  logic        q_push, q_full, q_pop, q_empty;
  arfs_entry_t q_entry, q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_PAUSE) ? {31'b0, pause_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_PAUSE) begin
      pause_q <= pwdata[0];
    end
  end

  arfs_front #(
    .RingBytes  (RingBytes),
    .BufferBytes(BufferBytes),
    .BufferSlots(BufferSlots),
    .FrameBytes (FrameBytes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pause_i   (pause_q),
    .in_valid_i(in_valid_i),
    .in_req_i  (in_req_i),
    .in_stall_o(in_stall_o),
    .q_push_o  (q_push),
    .q_entry_o (q_entry),
    .q_full_i  (q_full)
  );

  arfs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  arfs_back #(
    .RingBytes(RingBytes)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o),
    .out_stall_i(out_stall_i)
  );

endmodule
